// ===== src/lcdseq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the character LCD parallel sequencer.
// No dependencies; imported by lcdseq_charbuf and the top level.
package lcdseq_pkg;

    // Request codes on the cmd field
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_INIT  = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_GOTO  = 3'd3;
    localparam logic [2:0] CMD_LOAD  = 3'd4;

    // Request status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_READY = 2'd1;
    localparam logic [1:0] STS_OVERFLOW  = 2'd2;

    // Mode codes as reported on the mode field
    localparam logic [1:0] MODE_CODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_CODE_INIT = 2'd1;
    localparam logic [1:0] MODE_CODE_OPER = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FUNCTION_SET = 2'd0;
    localparam logic [1:0] CFG_DISPLAY_CTRL = 2'd1;
    localparam logic [1:0] CFG_ENTRY_MODE   = 2'd2;

    // Fixed bits of the LCD command bytes
    localparam logic [7:0] LCD_FUNCTION_SET_BASE = 8'h20;
    localparam logic [7:0] LCD_DISPLAY_CTRL_BASE = 8'h08;
    localparam logic [7:0] LCD_CLR_DISPLAY       = 8'h01;
    localparam logic [7:0] LCD_ENTRY_MODE_BASE   = 8'h04;
    localparam logic [7:0] LCD_DDRAM_BASE        = 8'd128;
    localparam logic [7:0] LCD_ROW2_OFFSET       = 8'd64;

    typedef enum logic [2:0] {
        MODE_OFF  = 3'b001,
        MODE_INIT = 3'b010,
        MODE_OPER = 3'b100
    } t_mode;

    typedef enum logic [5:0] {
        ST_POWER_ON = 6'b000001,
        ST_FSET     = 6'b000010,
        ST_DCTL     = 6'b000100,
        ST_CLEAR    = 6'b001000,
        ST_EMODE    = 6'b010000,
        ST_DONE     = 6'b100000
    } t_stage;

    typedef enum logic [3:0] {
        OP_NONE  = 4'b0001,
        OP_CLEAR = 4'b0010,
        OP_GOTO  = 4'b0100,
        OP_WRITE = 4'b1000
    } t_op;

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic [7:0] data_bus;
        logic       enable;
        logic       busy_res;
        logic [1:0] mode;
        logic [1:0] status;
    } t_result;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        case (m)
            MODE_INIT: c = MODE_CODE_INIT;
            MODE_OPER: c = MODE_CODE_OPER;
            default:   c = MODE_CODE_OFF;
        endcase
        return c;
    endfunction

endpackage

// ===== src/char_lcd_parallel_sequencer_core.sv =====
`timescale 1ns / 1ps
// Top level of the character LCD parallel sequencer (8-bit HD44780-style bus).
// Uses lcdseq_pkg and lcdseq_charbuf.
//
// Usage:
//   Every transfer on the input channel is one tick of the LCD sequencer:
//   cmd selects tick, start init, clear, goto or load character.  Each input
//   transfer yields exactly one result transfer carrying the pin levels
//   (rs, rw, data_bus, enable) after that tick, plus busy, mode and status.
//   A byte goes out as a two-tick strobe: enable rises, then falls.
//   Start init first; once mode reads operational and busy is low, clear,
//   goto and character loads are taken.  A load with last_char set starts
//   the write of the buffered string.
// Timing:
//   One input transfer per cycle while input ready is high; the result
//   is registered.  A two-entry output stage (output register plus skid
//   register) lets one more input be taken while a result waits; input
//   ready drops only when both entries are full.
// Reset:
//   Synchronous, active low.  Mode off, no request pending, pins low,
//   configuration registers at their default command bytes.
// Configuration:
//   Writes are always accepted (cfg ready is tied high); indexes beyond the
//   register list are ignored.
module char_lcd_parallel_sequencer_core
    import lcdseq_pkg::*;
#(
    parameter int STRING_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [5:0] i_cfg_data,

    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_in_cmd,
    input  logic [7:0] i_in_char_code,
    input  logic       i_in_last_char,
    input  logic       i_in_row,
    input  logic [3:0] i_in_column,

    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_out_rs,
    output logic       o_out_rw,
    output logic [7:0] o_out_data_bus,
    output logic       o_out_enable,
    output logic       o_out_busy_res,
    output logic [1:0] o_out_mode,
    output logic [1:0] o_out_status
);

    localparam int CW = $clog2(STRING_DEPTH + 1);
    localparam int AW = (STRING_DEPTH > 1) ? $clog2(STRING_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(STRING_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // Configuration registers
    logic [5:0] r_fset;
    logic [3:0] r_dctl;
    logic [2:0] r_emode;

    // Sequencer state
    t_mode         r_mode,  n_mode;
    t_stage        r_stage, n_stage;
    t_op           r_op,    n_op;
    logic          r_en,    n_en;
    logic          r_busy,  n_busy;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_index, n_index;
    logic          r_row,   n_row;
    logic [3:0]    r_col,   n_col;
    logic          r_pin_rs,   n_pin_rs;
    logic [7:0]    r_pin_data, n_pin_data;

    // Output stage
    t_result r_out, r_skid, res;
    logic    r_out_valid, r_skid_valid;

    logic          in_xfer, out_xfer, seq_ready;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    rd_data;
    logic [1:0]    status;
    logic [7:0]    goto_addr;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = r_out_valid && i_out_ready;
    assign seq_ready   = (r_mode == MODE_OPER) && !r_busy;

    // Character load write port
    assign wr_en   = in_xfer && (i_in_cmd == CMD_LOAD) && seq_ready && (r_count < DEPTH_C);
    assign wr_addr = r_count[AW-1:0];

    lcdseq_charbuf #(
        .DEPTH (STRING_DEPTH),
        .AW    (AW)
    ) u_charbuf (
        .i_clk      (i_clk),
        .i_advance  (in_xfer),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (i_in_char_code),
        .i_cur_addr (r_index[AW-1:0]),
        .i_nxt_addr (n_index[AW-1:0]),
        .o_rd_data  (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fset  <= 6'd56;
            r_dctl  <= 4'd12;
            r_emode <= 3'd6;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FUNCTION_SET: r_fset  <= i_cfg_data;
                CFG_DISPLAY_CTRL: r_dctl  <= i_cfg_data[3:0];
                CFG_ENTRY_MODE:   r_emode <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_stage    = r_stage;
        n_op       = r_op;
        n_en       = r_en;
        n_busy     = r_busy;
        n_count    = r_count;
        n_index    = r_index;
        n_row      = r_row;
        n_col      = r_col;
        n_pin_rs   = r_pin_rs;
        n_pin_data = r_pin_data;
        status     = STS_OK;
        goto_addr  = 8'h00;

        // Apply the request
        case (i_in_cmd)
            CMD_INIT: begin
                n_mode  = MODE_INIT;
                n_stage = ST_POWER_ON;
                n_en    = 1'b0;
                n_op    = OP_NONE;
                n_busy  = 1'b1;
                n_count = '0;
                n_index = '0;
            end
            CMD_CLEAR: begin
                if (!seq_ready) begin
                    status = STS_NOT_READY;
                end else begin
                    n_busy = 1'b1;
                    n_op   = OP_CLEAR;
                end
            end
            CMD_GOTO: begin
                if (!seq_ready) begin
                    status = STS_NOT_READY;
                end else begin
                    n_busy = 1'b1;
                    n_op   = OP_GOTO;
                    n_row  = i_in_row;
                    n_col  = i_in_column;
                end
            end
            CMD_LOAD: begin
                if (!seq_ready) begin
                    status = STS_NOT_READY;
                end else begin
                    if (r_count < DEPTH_C) begin
                        n_count = r_count + ONE_C;
                    end else begin
                        status = STS_OVERFLOW;
                    end
                    if (i_in_last_char) begin
                        n_busy  = 1'b1;
                        n_op    = OP_WRITE;
                        n_index = '0;
                    end
                end
            end
            default: ;
        endcase

        // Advance the sequencer one step
        if (n_mode == MODE_INIT) begin
            case (n_stage)
                ST_POWER_ON: begin
                    n_busy  = 1'b1;
                    n_stage = ST_FSET;
                end
                ST_FSET: begin
                    if (!n_en) begin
                        n_pin_rs   = 1'b0;
                        n_pin_data = LCD_FUNCTION_SET_BASE | {2'b00, r_fset};
                        n_en       = 1'b1;
                    end else begin
                        n_en    = 1'b0;
                        n_stage = ST_DCTL;
                    end
                end
                ST_DCTL: begin
                    if (!n_en) begin
                        n_pin_rs   = 1'b0;
                        n_pin_data = LCD_DISPLAY_CTRL_BASE | {4'b0000, r_dctl};
                        n_en       = 1'b1;
                    end else begin
                        n_en    = 1'b0;
                        n_stage = ST_CLEAR;
                    end
                end
                ST_CLEAR: begin
                    if (!n_en) begin
                        n_pin_rs   = 1'b0;
                        n_pin_data = LCD_CLR_DISPLAY;
                        n_en       = 1'b1;
                    end else begin
                        n_en    = 1'b0;
                        n_stage = ST_EMODE;
                    end
                end
                ST_EMODE: begin
                    if (!n_en) begin
                        n_pin_rs   = 1'b0;
                        n_pin_data = LCD_ENTRY_MODE_BASE | {5'b00000, r_emode};
                        n_en       = 1'b1;
                    end else begin
                        n_en    = 1'b0;
                        n_stage = ST_DONE;
                    end
                end
                default: begin
                    n_mode = MODE_OPER;
                    n_busy = 1'b0;
                    n_op   = OP_NONE;
                end
            endcase
        end else if (n_mode == MODE_OPER) begin
            case (n_op)
                OP_CLEAR: begin
                    if (!n_en) begin
                        n_pin_rs   = 1'b0;
                        n_pin_data = LCD_CLR_DISPLAY;
                        n_en       = 1'b1;
                    end else begin
                        n_en   = 1'b0;
                        n_busy = 1'b0;
                        n_op   = OP_NONE;
                    end
                end
                OP_GOTO: begin
                    goto_addr = LCD_DDRAM_BASE | {4'b0000, n_col}
                              | (n_row ? LCD_ROW2_OFFSET : 8'h00);
                    if (!n_en) begin
                        n_pin_rs   = 1'b0;
                        n_pin_data = goto_addr;
                        n_en       = 1'b1;
                    end else begin
                        n_en   = 1'b0;
                        n_busy = 1'b0;
                        n_op   = OP_NONE;
                    end
                end
                OP_WRITE: begin
                    if ((n_index < n_count) && (n_index < DEPTH_C)) begin
                        if (!n_en) begin
                            n_pin_rs   = 1'b1;
                            n_pin_data = rd_data;
                            n_en       = 1'b1;
                        end else begin
                            n_en    = 1'b0;
                            n_index = n_index + ONE_C;
                        end
                    end else begin
                        n_count = '0;
                        n_index = '0;
                        n_busy  = 1'b0;
                        n_op    = OP_NONE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        res          = '0;
        res.rs       = n_pin_rs;
        res.rw       = 1'b0;
        res.data_bus = n_pin_data;
        res.enable   = n_en;
        res.busy_res = n_busy;
        res.mode     = mode_code(n_mode);
        res.status   = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_OFF;
            r_stage    <= ST_POWER_ON;
            r_op       <= OP_NONE;
            r_en       <= 1'b0;
            r_busy     <= 1'b0;
            r_count    <= '0;
            r_index    <= '0;
            r_row      <= 1'b0;
            r_col      <= 4'd0;
            r_pin_rs   <= 1'b0;
            r_pin_data <= 8'h00;
        end else if (in_xfer) begin
            r_mode     <= n_mode;
            r_stage    <= n_stage;
            r_op       <= n_op;
            r_en       <= n_en;
            r_busy     <= n_busy;
            r_count    <= n_count;
            r_index    <= n_index;
            r_row      <= n_row;
            r_col      <= n_col;
            r_pin_rs   <= n_pin_rs;
            r_pin_data <= n_pin_data;
        end
    end

    // Output register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_xfer) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_xfer) begin
                r_out <= r_skid;
            end
        end else if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_rs       = r_out.rs;
    assign o_out_rw       = r_out.rw;
    assign o_out_data_bus = r_out.data_bus;
    assign o_out_enable   = r_out.enable;
    assign o_out_busy_res = r_out.busy_res;
    assign o_out_mode     = r_out.mode;
    assign o_out_status   = r_out.status;

endmodule

// ===== src/lcdseq_charbuf.sv =====
`timescale 1ns / 1ps
// Character string buffer: one write port and a registered read port that
// prefetches the next entry, with bypass of a same-cycle write.  Uses lcdseq_pkg.
module lcdseq_charbuf
    import lcdseq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_advance,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_cur_addr,
    input  logic [AW-1:0] i_nxt_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Prefetch the entry that the index points at after this transfer
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            if (i_wr_en && (i_wr_addr == i_nxt_addr)) begin
                r_rd <= i_wr_data;
            end else begin
                r_rd <= r_mem[i_nxt_addr];
            end
        end
    end

    assign o_rd_data = (i_wr_en && (i_wr_addr == i_cur_addr)) ? i_wr_data : r_rd;

endmodule
